[src/kst_pkg.sv]
package kst_pkg;

   localparam int COLUMNS     = 8;
   localparam int COL_W       = 3;
   localparam int ROW_W       = 4;
   localparam int TIME_W      = 32;
   localparam int CSR_INDEX_W = 3;

   localparam logic [1:0] OP_KEY_EVENT     = 2'd0;
   localparam logic [1:0] OP_STUCK_CHECK   = 2'd1;
   localparam logic [1:0] OP_FORCE_RELEASE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_MATRIX_ROWS      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATRIX_COLUMNS   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STUCK_TIMEOUT_MS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPS_KEY_CODE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPS_DEBOUNCE_MS = 3'd4;

   localparam logic [4:0]        MATRIX_ROWS_RESET      = 5'd14;
   localparam logic [3:0]        MATRIX_COLUMNS_RESET   = 4'd8;
   localparam logic [TIME_W-1:0] STUCK_TIMEOUT_RESET    = 32'd10000;
   localparam logic [6:0]        CAPS_KEY_CODE_RESET    = 7'd57;
   localparam logic [15:0]       CAPS_DEBOUNCE_RESET    = 16'd150;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [6:0]        key_code;
      logic              key_released;
      logic [ROW_W-1:0]  sweep_row;
      logic [TIME_W-1:0] now_ms;
   } req_word_type;

   typedef struct packed {
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      logic             out_pressed;
      logic             last_of_run;
   } rsp_word_type;

endpackage

[src/kst_ram.sv]
module kst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/kst_alu.sv]
module kst_alu (
   input  logic [kst_pkg::TIME_W-1:0] minuend,
   input  logic [kst_pkg::TIME_W-1:0] subtrahend,
   input  logic [kst_pkg::TIME_W-1:0] limit,
   input  logic                       limit_first,
   output logic                       less
);
   import kst_pkg::*;

   logic [TIME_W-1:0] diff;

   // wrapping elapsed time, then one shared magnitude compare
   assign diff = minuend - subtrahend;
   assign less = limit_first ? (limit < diff) : (diff < limit);

endmodule

[src/key_state_tracker.sv]
// Tracks held keys of a virtual matrix (row = code / 8, column = code % 8) and reports
// presses and releases, one word per result, the final word of each input marked by
// last_of_run. A plain key event gives one word, or a release and then a press for a
// repeated press; a caps key event first passes a debounce compare and then gives a
// press and a release. A force release gives one release per released key. A
// stuck-key check reads the press time memory one column per cycle through its single
// read port and then gives one release per expired key. One item is worked
// on at a time, and req_stall is high until its last result sits in the output register;
// a stalled rsp side holds the block in place. Items turned away in the idle state
// (code outside the matrix, unused opcode, empty or out-of-range row, disabled timeout)
// give no word; a dropped caps event also passes its debounce compare, and a stuck check
// that finds no expired key still runs the full scan.
module key_state_tracker #(
   parameter int MAX_ROWS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  kst_pkg::req_word_type               req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output kst_pkg::rsp_word_type               rsp_word,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kst_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [kst_pkg::TIME_W-1:0]          csr_wdata
);
   import kst_pkg::*;

   localparam int ROW_IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int PT_ADDR_W = ROW_IDX_W + COL_W;
   localparam int PT_DEPTH  = (1 << ROW_IDX_W) * COLUMNS;
   localparam int CNT_W     = COL_W + 1;
   localparam logic [ROW_W:0]   ROW_LIMIT = (ROW_W + 1)'(MAX_ROWS);
   localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(COLUMNS);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_CAPS = 6'b000010,
      S_SCAN = 6'b000100,
      S_LEAD = 6'b001000,
      S_TAIL = 6'b010000,
      S_EMIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [4:0]        matrix_rows_ff, matrix_rows_in;
   logic [3:0]        matrix_columns_ff, matrix_columns_in;
   logic [TIME_W-1:0] stuck_timeout_ff, stuck_timeout_in;
   logic [6:0]        caps_code_ff, caps_code_in;
   logic [15:0]       caps_debounce_ff, caps_debounce_in;

   logic [COLUMNS-1:0] held_ff [MAX_ROWS];
   logic [COLUMNS-1:0] held_in [MAX_ROWS];
   logic               caps_down_ff, caps_down_in;
   logic [TIME_W-1:0]  toggle_time_ff, toggle_time_in;

   logic [TIME_W-1:0]  now_ff, now_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic               key_pressed_ff, key_pressed_in;
   logic               tail_pressed_ff, tail_pressed_in;
   logic [COLUMNS-1:0] mask_ff, mask_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic [ROW_W-1:0]   ev_row;
   logic [COL_W-1:0]   ev_col;
   logic               ev_in_matrix;
   logic               ev_recorded;
   logic               ev_is_caps;
   logic               ev_pressed;
   logic [COLUMNS-1:0] ev_held;
   logic               sw_ok;
   logic [COLUMNS-1:0] sw_held;
   logic [COLUMNS-1:0] col_enable;
   logic [COLUMNS-1:0] row_held;
   logic [COL_W-1:0]   scan_col;
   logic [COLUMNS-1:0] scan_mask;
   logic [COL_W-1:0]   emit_col;
   logic [COLUMNS-1:0] emit_rest;
   logic               out_free;

   logic                 pt_wr_en;
   logic [PT_ADDR_W-1:0] pt_wr_addr;
   logic [PT_ADDR_W-1:0] pt_rd_addr;
   logic [TIME_W-1:0]    pt_rd_data;

   logic [TIME_W-1:0] alu_subtrahend;
   logic [TIME_W-1:0] alu_limit;
   logic              alu_limit_first;
   logic              alu_less;

   kst_ram #(
      .WIDTH (TIME_W),
      .DEPTH (PT_DEPTH)
   ) u_press_time (
      .clock   (clock),
      .wr_en   (pt_wr_en),
      .wr_addr (pt_wr_addr),
      .wr_data (req_word.now_ms),
      .rd_addr (pt_rd_addr),
      .rd_data (pt_rd_data)
   );

   kst_alu u_alu (
      .minuend     (now_ff),
      .subtrahend  (alu_subtrahend),
      .limit       (alu_limit),
      .limit_first (alu_limit_first),
      .less        (alu_less)
   );

   assign ev_row       = req_word.key_code[6:COL_W];
   assign ev_col       = req_word.key_code[COL_W-1:0];
   assign ev_pressed   = !req_word.key_released;
   assign ev_in_matrix = ({1'b0, ev_row} < matrix_rows_ff) &&
                         ({1'b0, ev_col} < matrix_columns_ff);
   assign ev_recorded  = {1'b0, ev_row} < ROW_LIMIT;
   assign ev_is_caps   = req_word.key_code == caps_code_ff;
   assign ev_held      = ev_recorded ? held_ff[ev_row[ROW_IDX_W-1:0]] : '0;

   assign sw_ok   = ({1'b0, req_word.sweep_row} < matrix_rows_ff) &&
                    ({1'b0, req_word.sweep_row} < ROW_LIMIT);
   assign sw_held = sw_ok ? held_ff[req_word.sweep_row[ROW_IDX_W-1:0]] : '0;

   assign row_held = held_ff[row_ff[ROW_IDX_W-1:0]];

   always_comb begin
      for (int c = 0; c < COLUMNS; c++) begin
         col_enable[c] = {1'b0, COL_W'(c)} < matrix_columns_ff;
      end
   end

   // lowest pending column of a row sweep
   always_comb begin
      emit_col = '0;
      for (int i = COLUMNS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            emit_col = COL_W'(i);
         end
      end
      emit_rest           = mask_ff;
      emit_rest[emit_col] = 1'b0;
   end

   assign scan_col = cnt_ff[COL_W-1:0] - COL_W'(1);

   always_comb begin
      scan_mask = mask_ff;
      if (cnt_ff != '0 && row_held[scan_col] && col_enable[scan_col] && alu_less) begin
         scan_mask[scan_col] = 1'b1;
      end
   end

   assign alu_subtrahend  = (state_ff == S_CAPS) ? toggle_time_ff : pt_rd_data;
   assign alu_limit       = (state_ff == S_CAPS) ? {16'b0, caps_debounce_ff} : stuck_timeout_ff;
   assign alu_limit_first = state_ff != S_CAPS;

   assign pt_rd_addr = {row_ff[ROW_IDX_W-1:0], cnt_ff[COL_W-1:0]};
   assign pt_wr_addr = {ev_row[ROW_IDX_W-1:0], ev_col};
   assign pt_wr_en   = (state_ff == S_IDLE) && req_valid &&
                       (req_word.opcode == OP_KEY_EVENT) && ev_in_matrix && !ev_is_caps &&
                       ev_recorded && ev_pressed;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in        = state_ff;
      held_in         = held_ff;
      caps_down_in    = caps_down_ff;
      toggle_time_in  = toggle_time_ff;
      now_in          = now_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      key_pressed_in  = key_pressed_ff;
      tail_pressed_in = tail_pressed_ff;
      mask_in         = mask_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_word_in     = rsp_word_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               now_in         = req_word.now_ms;
               key_pressed_in = ev_pressed;
               unique case (req_word.opcode)
                  OP_KEY_EVENT: begin
                     row_in = ev_row;
                     col_in = ev_col;
                     if (ev_in_matrix) begin
                        if (ev_is_caps) begin
                           state_in = S_CAPS;
                        end else begin
                           if (ev_recorded) begin
                              held_in[ev_row[ROW_IDX_W-1:0]][ev_col] = ev_pressed;
                           end
                           tail_pressed_in = ev_pressed;
                           state_in        = (ev_pressed && ev_held[ev_col]) ? S_LEAD : S_TAIL;
                        end
                     end
                  end
                  OP_STUCK_CHECK: begin
                     row_in = req_word.sweep_row;
                     if (stuck_timeout_ff != '0 && sw_held != '0) begin
                        mask_in  = '0;
                        cnt_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  OP_FORCE_RELEASE: begin
                     row_in = req_word.sweep_row;
                     if (sw_held != '0) begin
                        held_in[req_word.sweep_row[ROW_IDX_W-1:0]] = '0;
                        mask_in = sw_held & col_enable;
                        if ((sw_held & col_enable) != '0) begin
                           state_in = S_EMIT;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CAPS: begin
            if (!alu_less && key_pressed_ff != caps_down_ff) begin
               caps_down_in    = key_pressed_ff;
               toggle_time_in  = now_ff;
               tail_pressed_in = 1'b0;
               state_in        = S_LEAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            mask_in = scan_mask;
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == SCAN_LAST) begin
               held_in[row_ff[ROW_IDX_W-1:0]] = row_held & ~scan_mask;
               state_in = (scan_mask != '0) ? S_EMIT : S_IDLE;
            end
         end
         S_LEAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{out_row: row_ff, out_col: col_ff,
                                out_pressed: !tail_pressed_ff, last_of_run: 1'b0};
               state_in     = S_TAIL;
            end
         end
         S_TAIL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{out_row: row_ff, out_col: col_ff,
                                out_pressed: tail_pressed_ff, last_of_run: 1'b1};
               state_in     = S_IDLE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{out_row: row_ff, out_col: emit_col,
                                out_pressed: 1'b0, last_of_run: emit_rest == '0};
               mask_in      = emit_rest;
               if (emit_rest == '0) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      matrix_rows_in    = matrix_rows_ff;
      matrix_columns_in = matrix_columns_ff;
      stuck_timeout_in  = stuck_timeout_ff;
      caps_code_in      = caps_code_ff;
      caps_debounce_in  = caps_debounce_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MATRIX_ROWS:      matrix_rows_in    = csr_wdata[4:0];
            CSR_MATRIX_COLUMNS:   matrix_columns_in = csr_wdata[3:0];
            CSR_STUCK_TIMEOUT_MS: stuck_timeout_in  = csr_wdata;
            CSR_CAPS_KEY_CODE:    caps_code_in      = csr_wdata[6:0];
            CSR_CAPS_DEBOUNCE_MS: caps_debounce_in  = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         held_ff           <= '{default: '0};
         caps_down_ff      <= 1'b0;
         toggle_time_ff    <= '0;
         rsp_valid_ff      <= 1'b0;
         matrix_rows_ff    <= MATRIX_ROWS_RESET;
         matrix_columns_ff <= MATRIX_COLUMNS_RESET;
         stuck_timeout_ff  <= STUCK_TIMEOUT_RESET;
         caps_code_ff      <= CAPS_KEY_CODE_RESET;
         caps_debounce_ff  <= CAPS_DEBOUNCE_RESET;
      end else begin
         state_ff          <= state_in;
         held_ff           <= held_in;
         caps_down_ff      <= caps_down_in;
         toggle_time_ff    <= toggle_time_in;
         rsp_valid_ff      <= rsp_valid_in;
         matrix_rows_ff    <= matrix_rows_in;
         matrix_columns_ff <= matrix_columns_in;
         stuck_timeout_ff  <= stuck_timeout_in;
         caps_code_ff      <= caps_code_in;
         caps_debounce_ff  <= caps_debounce_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff          <= now_in;
      row_ff          <= row_in;
      col_ff          <= col_in;
      key_pressed_ff  <= key_pressed_in;
      tail_pressed_ff <= tail_pressed_in;
      mask_ff         <= mask_in;
      cnt_ff          <= cnt_in;
      rsp_word_ff     <= rsp_word_in;
   end

   assign req_stall = state_ff != S_IDLE;
   assign csr_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[src/kst_checker.sv]
module kst_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input kst_pkg::rsp_word_type           rsp_word,
   input logic                            csr_ready
);
   import kst_pkg::*;

   // a stalled result word stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled rsp word changed");

   // no new input while a run is still being delivered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.last_of_run |-> req_stall)
      else $error("input taken in the middle of a run");

   // config and input sides open together
   assert property (@(posedge clock) disable iff (reset)
      csr_ready == !req_stall)
      else $error("csr ready and req stall disagree");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind key_state_tracker kst_checker u_kst_checker (.*);
